/* design/accumulator_cpu_instruction_step_assert.svh */
// Assertion helpers included by the top-level design file.
`ifndef ACCUMULATOR_CPU_INSTRUCTION_STEP_ASSERT_SVH
`define ACCUMULATOR_CPU_INSTRUCTION_STEP_ASSERT_SVH

// Same-cycle implication.
`define ACIS_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ACIS_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/acis_pkg.sv */
`default_nettype none
package acis_pkg;

    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = 16;

    // Item opcodes on the input channel.
    localparam logic [1:0] ITEM_WR   = 2'd0;
    localparam logic [1:0] ITEM_RD   = 2'd1;
    localparam logic [1:0] ITEM_EXEC = 2'd2;

    localparam logic [1:0] HALT_RUN = 2'd0;
    localparam logic [1:0] HALT_NOP = 2'd1;
    localparam logic [1:0] HALT_BAD = 2'd2;

    localparam logic [7:0] SP_INIT_VAL = 8'hFE;

    // Instruction opcodes.
    localparam logic [7:0] OP_NOP     = 8'h00;
    localparam logic [7:0] OP_OUT     = 8'h01;
    localparam logic [7:0] OP_IN      = 8'h02;
    localparam logic [7:0] OP_LDA_I   = 8'h03;
    localparam logic [7:0] OP_LDX_I   = 8'h04;
    localparam logic [7:0] OP_LDY_I   = 8'h05;
    localparam logic [7:0] OP_LDA_M   = 8'h06;
    localparam logic [7:0] OP_LDA_MX  = 8'h07;
    localparam logic [7:0] OP_LDA_MY  = 8'h08;
    localparam logic [7:0] OP_LDA_IND = 8'h09;
    localparam logic [7:0] OP_STA_M   = 8'h0A;
    localparam logic [7:0] OP_STX_M   = 8'h0B;
    localparam logic [7:0] OP_STY_M   = 8'h0C;
    localparam logic [7:0] OP_STA_MX  = 8'h0D;
    localparam logic [7:0] OP_STA_MY  = 8'h0E;
    localparam logic [7:0] OP_STA_IND = 8'h0F;
    localparam logic [7:0] OP_INA     = 8'h10;
    localparam logic [7:0] OP_INX     = 8'h11;
    localparam logic [7:0] OP_INY     = 8'h12;
    localparam logic [7:0] OP_DEA     = 8'h13;
    localparam logic [7:0] OP_DEX     = 8'h14;
    localparam logic [7:0] OP_DEY     = 8'h15;
    localparam logic [7:0] OP_TAX     = 8'h16;
    localparam logic [7:0] OP_TXA     = 8'h17;
    localparam logic [7:0] OP_TYA     = 8'h18;
    localparam logic [7:0] OP_TAY     = 8'h19;
    localparam logic [7:0] OP_TXY     = 8'h1A;
    localparam logic [7:0] OP_TYX     = 8'h1B;
    localparam logic [7:0] OP_LDA_SP  = 8'h1C;
    localparam logic [7:0] OP_STA_SP  = 8'h1D;
    localparam logic [7:0] OP_SEC     = 8'h1E;
    localparam logic [7:0] OP_CLC     = 8'h1F;
    localparam logic [7:0] OP_ADD_I   = 8'h20;
    localparam logic [7:0] OP_ADD_M   = 8'h21;
    localparam logic [7:0] OP_ADD_X   = 8'h22;
    localparam logic [7:0] OP_ADD_Y   = 8'h23;
    localparam logic [7:0] OP_SUB_I   = 8'h24;
    localparam logic [7:0] OP_SUB_M   = 8'h25;
    localparam logic [7:0] OP_SUB_X   = 8'h26;
    localparam logic [7:0] OP_SUB_Y   = 8'h27;
    localparam logic [7:0] OP_NAND_I  = 8'h28;
    localparam logic [7:0] OP_NAND_M  = 8'h29;
    localparam logic [7:0] OP_NAND_X  = 8'h2A;
    localparam logic [7:0] OP_NAND_Y  = 8'h2B;
    localparam logic [7:0] OP_ROL1    = 8'h2C;
    localparam logic [7:0] OP_ROL2    = 8'h2D;
    localparam logic [7:0] OP_ROL4    = 8'h2E;
    localparam logic [7:0] OP_AND_I   = 8'h2F;
    localparam logic [7:0] OP_OR_I    = 8'h30;
    localparam logic [7:0] OP_NOT     = 8'h31;
    localparam logic [7:0] OP_XOR_I   = 8'h32;
    localparam logic [7:0] OP_JMP     = 8'h33;
    localparam logic [7:0] OP_JZ      = 8'h34;
    localparam logic [7:0] OP_JC      = 8'h35;
    localparam logic [7:0] OP_JMP_IND = 8'h36;
    localparam logic [7:0] OP_SP_INIT = 8'h37;
    localparam logic [7:0] OP_PHA     = 8'h38;
    localparam logic [7:0] OP_PHX     = 8'h39;
    localparam logic [7:0] OP_PHY     = 8'h3A;
    localparam logic [7:0] OP_PLA     = 8'h3B;
    localparam logic [7:0] OP_PLX     = 8'h3C;
    localparam logic [7:0] OP_PLY     = 8'h3D;
    localparam logic [7:0] OP_JSR     = 8'h3E;
    localparam logic [7:0] OP_RTS     = 8'h3F;
    localparam logic [7:0] OP_LDA_S   = 8'h40;
    localparam logic [7:0] OP_STA_S   = 8'h41;
    localparam logic [7:0] OP_CMP_I   = 8'h42;
    localparam logic [7:0] OP_CMP_M   = 8'h43;
    localparam logic [7:0] OP_CPX_I   = 8'h44;
    localparam logic [7:0] OP_CPY_I   = 8'h45;
    localparam logic [7:0] OP_CLR_M   = 8'h46;
    localparam logic [7:0] OP_AND_I2  = 8'h47;
    localparam logic [7:0] OP_INC_M   = 8'h48;
    localparam logic [7:0] OP_DEC_M   = 8'h49;
    localparam logic [7:0] OP_PH_I    = 8'h4A;
    localparam logic [7:0] OP_ROLA    = 8'h4B;
    localparam logic [7:0] OP_ROL_M   = 8'h4C;
    localparam logic [7:0] OP_OR_M    = 8'h4D;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_EXEC,
        CMD_NONE
    } t_cmd;

    typedef enum logic [1:0] {
        OPND_NONE,
        OPND_B8,
        OPND_W16
    } t_opnd;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_OP, ST_DEC, ST_B1, ST_B2, ST_EXEC,
        ST_MEMRD, ST_IND1, ST_IND2, ST_RMW, ST_SPR,
        ST_PL0, ST_PL1, ST_PL2, ST_PL3,
        ST_PU0, ST_PU1, ST_PU2, ST_PU3,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
        logic [7:0]  in_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] prog_counter;
        logic [7:0]  accum;
        logic [7:0]  reg_a_val;
        logic [7:0]  reg_x_val;
        logic [7:0]  reg_y_val;
        logic        zero_bit;
        logic        carry_bit;
        logic        out_valid;
        logic [7:0]  out_char;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  in_char;
    } t_q_item;

    typedef struct packed {
        logic    valid;
        t_q_item item;
    } t_q_port;

    typedef struct packed {
        logic [7:0] acc;
        logic       cf;
        logic       zf;
    } t_alu;

    function automatic t_opnd f_opnd(input logic [7:0] op);
        t_opnd k;
        case (op) inside
            OP_LDA_I, OP_LDX_I, OP_LDY_I, OP_ADD_I, OP_SUB_I, OP_NAND_I, OP_AND_I,
            OP_AND_I2, OP_OR_I, OP_XOR_I, OP_LDA_S, OP_STA_S, OP_CMP_I, OP_CPX_I,
            OP_CPY_I, OP_PH_I:
                k = OPND_B8;
            OP_OUT, OP_IN, OP_LDA_M, OP_LDA_MX, OP_LDA_MY, OP_LDA_IND, OP_STA_M,
            OP_STX_M, OP_STY_M, OP_STA_MX, OP_STA_MY, OP_STA_IND, OP_ADD_M,
            OP_SUB_M, OP_NAND_M, OP_JMP, OP_JZ, OP_JC, OP_JMP_IND, OP_JSR,
            OP_CMP_M, OP_CLR_M, OP_INC_M, OP_DEC_M, OP_ROL_M, OP_OR_M:
                k = OPND_W16;
            default:
                k = OPND_NONE;
        endcase
        return k;
    endfunction

    function automatic t_alu f_load(input logic [7:0] v);
        t_alu r;
        r.acc = v;
        r.cf  = 1'b0;
        r.zf  = (v == 8'h00);
        return r;
    endfunction

    // The accumulator is cleared, A plus carry goes in, then the operand
    // plus the carry out of that first add.
    function automatic t_alu f_add(input logic [7:0] a, input logic [7:0] v,
                                   input logic cin);
        t_alu       r;
        logic [8:0] s1;
        logic [8:0] s2;
        s1    = {1'b0, a} + {8'h00, cin};
        s2    = {1'b0, s1[7:0]} + {1'b0, v} + {8'h00, s1[8]};
        r.acc = s2[7:0];
        r.cf  = s2[8];
        r.zf  = (s2[7:0] == 8'h00);
        return r;
    endfunction

    function automatic t_alu f_sub(input logic [7:0] a, input logic [7:0] v,
                                   input logic cin);
        t_alu       r;
        logic [8:0] s;
        s     = {1'b0, a} + {1'b0, ~v} + {8'h00, cin};
        r.acc = s[7:0];
        r.cf  = s[8];
        r.zf  = (s[7:0] == 8'h00);
        return r;
    endfunction

    function automatic t_alu f_incdec(input logic [7:0] v, input logic up);
        t_alu       r;
        logic [8:0] s;
        s     = {1'b0, v} + (up ? 9'h001 : 9'h0FF);
        r.acc = s[7:0];
        r.cf  = s[8];
        r.zf  = (s[7:0] == 8'h00);
        return r;
    endfunction

    function automatic logic [7:0] f_rotl1(input logic [7:0] v);
        return {v[6:0], v[7]};
    endfunction

endpackage
`default_nettype wire

/* design/acis_chan_if.sv */
`default_nettype none
interface acis_in_if import acis_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface acis_out_if import acis_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/accumulator_cpu_instruction_step.sv */
`default_nettype none
// Channel  Dir  Word                                           Accepted when
// i_in     in   opcode, mem_addr, mem_data, in_char            valid && ready
// o_out    out  read_data, prog_counter, accum, regs, flags,   valid && ready
//               out_valid, out_char, status
//
// After reset the RAM is cleared one byte a cycle, before any word is executed.
// Words are queued two deep in front of the executor, which uses one single-port
// RAM access a cycle. An instruction takes longer the more RAM accesses it needs,
// a subroutine call longest.
// A result waits in the output register; the next word starts once it is taken.
module accumulator_cpu_instruction_step import acis_pkg::*; #(
    parameter logic [15:0] STACK_BASE = 16'hFF00,
    parameter logic [15:0] SP_CELL    = 16'hFFFF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    acis_in_if.sink    i_in,
    acis_out_if.source o_out
);

    t_q_port w_q;
    logic    w_pop;

    acis_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_q     (w_q),
        .i_pop   (w_pop)
    );

    acis_back #(
        .STACK_BASE (STACK_BASE),
        .SP_CELL    (SP_CELL)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

`include "accumulator_cpu_instruction_step_assert.svh"

    `ACIS_IMPL(a_pop_needs_word, i_clk, i_rst_n, w_pop, w_q.valid)
    `ACIS_NEXT(a_pop_no_early_out, i_clk, i_rst_n, w_pop, !o_out.valid)
    `ACIS_IMPL(a_char_zero, i_clk, i_rst_n, o_out.valid && !o_out.data.out_valid,
               o_out.data.out_char == 8'h00)

endmodule
`default_nettype wire

/* design/acis_front.sv */
`default_nettype none
module acis_front import acis_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    acis_in_if.sink   i_in,
    output t_q_port   o_q,
    input  logic      i_pop
);

    localparam int QD  = 2;
    localparam int QAW = $clog2(QD);

    t_q_item          r_q [QD];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    t_q_item          w_item;
    logic             w_push;

    always_comb begin
        w_item.addr    = i_in.data.mem_addr;
        w_item.data    = i_in.data.mem_data;
        w_item.in_char = i_in.data.in_char;
        unique case (i_in.data.opcode)
            ITEM_WR:   w_item.cmd = CMD_WRITE;
            ITEM_RD:   w_item.cmd = CMD_READ;
            ITEM_EXEC: w_item.cmd = CMD_EXEC;
            default:   w_item.cmd = CMD_NONE;
        endcase
    end

    assign i_in.ready = (r_cnt != QD[QAW:0]);
    assign w_push     = i_in.valid & i_in.ready;
    assign o_q.valid  = (r_cnt != '0);
    assign o_q.item   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{QAW{1'b0}}, w_push} - {{QAW{1'b0}}, i_pop};
        end
    end

endmodule
`default_nettype wire

/* design/acis_back.sv */
`default_nettype none
module acis_back import acis_pkg::*; #(
    parameter logic [15:0] STACK_BASE = 16'hFF00,
    parameter logic [15:0] SP_CELL    = 16'hFFFF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_port    i_q,
    output logic       o_pop,
    acis_out_if.source o_out
);

    logic [7:0]  r_mem [MEM_DEPTH];
    logic [7:0]  r_rdata;
    logic [MEM_AW-1:0] w_ma;
    logic        w_we;
    logic [7:0]  w_wd;

    t_state      r_state, n_state;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_acc, n_acc, r_a, n_a, r_x, n_x, r_y, n_y;
    logic        r_cf, n_cf, r_zf, n_zf;
    logic [1:0]  r_halt, n_halt;
    logic [7:0]  r_op, n_op, r_lo, n_lo, r_hi, n_hi, r_pv, n_pv, r_sp, n_sp;
    logic [15:0] r_t16, n_t16, r_ret, n_ret;
    logic        r_second, n_second;
    t_cmd        r_cmd, n_cmd;
    logic [7:0]  r_inc, n_inc, r_oc, n_oc;
    logic        r_ov, n_ov;
    logic [15:0] r_clr;
    logic        r_ovalid, n_ovalid;
    t_out_item   r_out, n_out;

    // Single-port RAM with registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_ma] <= w_wd;
        end
        r_rdata <= r_mem[w_ma];
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_pv     <= n_pv;
        r_sp     <= n_sp;
        r_t16    <= n_t16;
        r_ret    <= n_ret;
        r_second <= n_second;
        r_cmd    <= n_cmd;
        r_inc    <= n_inc;
        r_oc     <= n_oc;
        r_ov     <= n_ov;
        r_out    <= n_out;
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_pc     <= '0;
            r_acc    <= '0;
            r_a      <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_cf     <= 1'b0;
            r_zf     <= 1'b0;
            r_halt   <= HALT_RUN;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_acc    <= n_acc;
            r_a      <= n_a;
            r_x      <= n_x;
            r_y      <= n_y;
            r_cf     <= n_cf;
            r_zf     <= n_zf;
            r_halt   <= n_halt;
            r_ovalid <= n_ovalid;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 16'd1;
            end
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    always_comb begin
        t_alu        alu;
        logic [15:0] ea;
        logic        do_alu;
        logic        do_seta;

        alu      = f_load(8'h00);
        ea       = '0;
        do_alu   = 1'b0;
        do_seta  = 1'b0;
        n_state  = r_state;
        n_pc     = r_pc;
        n_acc    = r_acc;
        n_a      = r_a;
        n_x      = r_x;
        n_y      = r_y;
        n_cf     = r_cf;
        n_zf     = r_zf;
        n_halt   = r_halt;
        n_op     = r_op;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_pv     = r_pv;
        n_sp     = r_sp;
        n_t16    = r_t16;
        n_ret    = r_ret;
        n_second = r_second;
        n_cmd    = r_cmd;
        n_inc    = r_inc;
        n_oc     = r_oc;
        n_ov     = r_ov;
        n_out    = r_out;
        n_ovalid = r_ovalid & ~o_out.ready;
        o_pop    = 1'b0;
        w_ma     = r_pc;
        w_we     = 1'b0;
        w_wd     = 8'h00;

        unique case (r_state)
            ST_CLEAR: begin
                w_ma = r_clr;
                w_we = 1'b1;
                if (r_clr == 16'hFFFF) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q.valid && !r_ovalid) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_q.item.cmd;
                    n_inc  = i_q.item.in_char;
                    n_ov   = 1'b0;
                    n_oc   = 8'h00;
                    w_ma   = i_q.item.addr;
                    n_state = ST_DONE;
                    case (i_q.item.cmd)
                        CMD_WRITE: begin
                            w_we = 1'b1;
                            w_wd = i_q.item.data;
                        end
                        CMD_EXEC: begin
                            if (r_halt == HALT_RUN) begin
                                n_state = ST_OP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_OP: begin
                w_ma    = r_pc;
                n_pc    = r_pc + 16'd1;
                n_state = ST_DEC;
            end
            ST_DEC: begin
                n_op  = r_rdata;
                n_ret = r_pc;
                if (r_rdata == OP_NOP) begin
                    n_halt  = HALT_NOP;
                    n_state = ST_DONE;
                end else if (r_rdata > OP_OR_M) begin
                    n_halt  = HALT_BAD;
                    n_state = ST_DONE;
                end else if (f_opnd(r_rdata) == OPND_NONE) begin
                    n_state = ST_EXEC;
                end else begin
                    w_ma    = r_pc;
                    n_pc    = r_pc + 16'd1;
                    n_state = ST_B1;
                end
            end
            ST_B1: begin
                n_lo = r_rdata;
                if (f_opnd(r_op) == OPND_W16) begin
                    w_ma    = r_pc;
                    n_pc    = r_pc + 16'd1;
                    n_state = ST_B2;
                end else begin
                    n_state = ST_EXEC;
                end
            end
            ST_B2: begin
                n_t16   = {r_rdata, r_lo};
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                unique case (r_op) inside
                    OP_OUT: begin
                        alu = f_load(r_a); do_alu = 1'b1;
                        if (r_t16 == 16'd1) begin
                            n_ov = 1'b1;
                            n_oc = r_a;
                        end
                    end
                    OP_IN: begin
                        if (r_t16 == 16'd2) begin
                            alu = f_load(r_inc); do_seta = 1'b1;
                        end
                    end
                    OP_LDA_I: begin alu = f_load(r_lo); do_seta = 1'b1; end
                    OP_LDX_I: begin alu = f_load(r_lo); do_alu = 1'b1; n_x = r_lo; end
                    OP_LDY_I: begin alu = f_load(r_lo); do_alu = 1'b1; n_y = r_lo; end
                    OP_LDA_M, OP_ADD_M, OP_SUB_M, OP_NAND_M, OP_CMP_M, OP_OR_M: begin
                        w_ma = r_t16; n_state = ST_MEMRD;
                    end
                    OP_LDA_MX: begin w_ma = r_t16 + {8'h00, r_x}; n_state = ST_MEMRD; end
                    OP_LDA_MY: begin w_ma = r_t16 + {8'h00, r_y}; n_state = ST_MEMRD; end
                    OP_LDA_IND, OP_STA_IND, OP_JMP_IND: begin
                        w_ma = r_t16; n_state = ST_IND1;
                    end
                    OP_STA_M: begin w_ma = r_t16; w_we = 1'b1; w_wd = r_a; end
                    OP_STX_M: begin w_ma = r_t16; w_we = 1'b1; w_wd = r_x; end
                    OP_STY_M: begin w_ma = r_t16; w_we = 1'b1; w_wd = r_y; end
                    OP_STA_MX: begin
                        w_ma = r_t16 + {8'h00, r_x}; w_we = 1'b1; w_wd = r_a;
                    end
                    OP_STA_MY: begin
                        w_ma = r_t16 + {8'h00, r_y}; w_we = 1'b1; w_wd = r_a;
                    end
                    OP_CLR_M: begin w_ma = r_t16; w_we = 1'b1; w_wd = 8'h00; end
                    OP_INA: begin alu = f_incdec(r_a, 1'b1); do_seta = 1'b1; end
                    OP_DEA: begin alu = f_incdec(r_a, 1'b0); do_seta = 1'b1; end
                    OP_INX: begin alu = f_incdec(r_x, 1'b1); do_alu = 1'b1; n_x = alu.acc; end
                    OP_DEX: begin alu = f_incdec(r_x, 1'b0); do_alu = 1'b1; n_x = alu.acc; end
                    OP_INY: begin alu = f_incdec(r_y, 1'b1); do_alu = 1'b1; n_y = alu.acc; end
                    OP_DEY: begin alu = f_incdec(r_y, 1'b0); do_alu = 1'b1; n_y = alu.acc; end
                    OP_TAX: n_x = r_a;
                    OP_TAY: n_y = r_a;
                    OP_TXY: n_y = r_x;
                    OP_TYX: n_x = r_y;
                    OP_TXA: begin alu = f_load(r_x); do_seta = 1'b1; end
                    OP_TYA: begin alu = f_load(r_y); do_seta = 1'b1; end
                    OP_LDA_SP: begin w_ma = SP_CELL; n_state = ST_MEMRD; end
                    OP_STA_SP: begin
                        alu = f_load(r_a); do_alu = 1'b1;
                        w_ma = SP_CELL; w_we = 1'b1; w_wd = r_a;
                    end
                    OP_SEC: n_cf = 1'b1;
                    OP_CLC: n_cf = 1'b0;
                    OP_ADD_I: begin alu = f_add(r_a, r_lo, r_cf); do_seta = 1'b1; end
                    OP_ADD_X: begin alu = f_add(r_a, r_x, r_cf); do_seta = 1'b1; end
                    OP_ADD_Y: begin alu = f_add(r_a, r_y, r_cf); do_seta = 1'b1; end
                    OP_SUB_I: begin alu = f_sub(r_a, r_lo, r_cf); do_seta = 1'b1; end
                    OP_SUB_X: begin alu = f_sub(r_a, r_x, r_cf); do_seta = 1'b1; end
                    OP_SUB_Y: begin alu = f_sub(r_a, r_y, r_cf); do_seta = 1'b1; end
                    OP_NAND_I: begin alu = f_load(~(r_a & r_lo)); do_seta = 1'b1; end
                    OP_NAND_X: begin alu = f_load(~(r_a & r_x)); do_seta = 1'b1; end
                    OP_NAND_Y: begin alu = f_load(~(r_a & r_y)); do_seta = 1'b1; end
                    OP_ROL1: begin alu = f_load(f_rotl1(r_a)); do_seta = 1'b1; end
                    OP_ROL2: begin alu = f_load({r_a[5:0], r_a[7:6]}); do_seta = 1'b1; end
                    OP_ROL4: begin alu = f_load({r_a[3:0], r_a[7:4]}); do_seta = 1'b1; end
                    OP_AND_I, OP_AND_I2: begin alu = f_load(r_a & r_lo); do_seta = 1'b1; end
                    OP_OR_I: begin alu = f_load(r_a | r_lo); do_seta = 1'b1; end
                    OP_NOT: begin alu = f_load(~r_a); do_seta = 1'b1; end
                    OP_XOR_I: begin alu = f_load(r_a ^ r_lo); do_seta = 1'b1; end
                    OP_JMP: n_pc = r_t16;
                    OP_JZ: begin
                        if (r_zf) begin
                            n_pc = r_t16;
                        end
                    end
                    OP_JC: begin
                        if (r_cf) begin
                            n_pc = r_t16;
                        end
                    end
                    OP_SP_INIT: begin w_ma = SP_CELL; w_we = 1'b1; w_wd = SP_INIT_VAL; end
                    OP_PHA: begin n_pv = r_a; n_second = 1'b0; n_state = ST_PU0; end
                    OP_PHX: begin n_pv = r_x; n_second = 1'b0; n_state = ST_PU0; end
                    OP_PHY: begin n_pv = r_y; n_second = 1'b0; n_state = ST_PU0; end
                    OP_PH_I: begin n_pv = r_lo; n_second = 1'b0; n_state = ST_PU0; end
                    OP_JSR: begin
                        n_pv = r_ret[7:0]; n_second = 1'b0; n_state = ST_PU0;
                    end
                    OP_PLA, OP_PLX, OP_PLY, OP_RTS: begin
                        n_second = 1'b0; n_state = ST_PL0;
                    end
                    OP_LDA_S, OP_STA_S: begin w_ma = SP_CELL; n_state = ST_SPR; end
                    OP_CMP_I: begin alu = f_sub(r_a, r_lo, 1'b1); do_alu = 1'b1; end
                    OP_CPX_I: begin alu = f_sub(r_x, r_lo, 1'b1); do_alu = 1'b1; end
                    OP_CPY_I: begin alu = f_sub(r_y, r_lo, 1'b1); do_alu = 1'b1; end
                    OP_INC_M, OP_DEC_M, OP_ROL_M: begin w_ma = r_t16; n_state = ST_RMW; end
                    OP_ROLA: begin
                        n_acc = 8'h00;
                        n_zf  = 1'b1;
                        n_a   = f_rotl1(r_a);
                    end
                    default: ;
                endcase
            end
            ST_MEMRD: begin
                n_state = ST_DONE;
                unique case (r_op) inside
                    OP_ADD_M:  begin alu = f_add(r_a, r_rdata, r_cf); do_seta = 1'b1; end
                    OP_SUB_M:  begin alu = f_sub(r_a, r_rdata, r_cf); do_seta = 1'b1; end
                    OP_NAND_M: begin alu = f_load(~(r_a & r_rdata)); do_seta = 1'b1; end
                    OP_CMP_M:  begin alu = f_sub(r_a, r_rdata, 1'b1); do_alu = 1'b1; end
                    OP_OR_M:   begin alu = f_load(r_a | r_rdata); do_seta = 1'b1; end
                    default:   begin alu = f_load(r_rdata); do_seta = 1'b1; end
                endcase
            end
            ST_IND1: begin
                n_lo    = r_rdata;
                w_ma    = r_t16 + 16'd1;
                n_state = ST_IND2;
            end
            ST_IND2: begin
                ea      = {r_rdata, r_lo};
                n_state = ST_DONE;
                unique case (r_op) inside
                    OP_LDA_IND: begin w_ma = ea; n_state = ST_MEMRD; end
                    OP_STA_IND: begin w_ma = ea; w_we = 1'b1; w_wd = r_a; end
                    default:    n_pc = ea;
                endcase
            end
            ST_RMW: begin
                w_ma    = r_t16;
                w_we    = 1'b1;
                n_state = ST_DONE;
                unique case (r_op) inside
                    OP_INC_M: begin
                        alu = f_incdec(r_rdata, 1'b1); do_alu = 1'b1; w_wd = alu.acc;
                    end
                    OP_DEC_M: begin
                        alu = f_incdec(r_rdata, 1'b0); do_alu = 1'b1; w_wd = alu.acc;
                    end
                    default: begin
                        n_acc = 8'h00;
                        n_zf  = 1'b1;
                        w_wd  = f_rotl1(r_rdata);
                    end
                endcase
            end
            ST_SPR: begin
                ea      = (STACK_BASE | {8'h00, r_rdata}) + {8'h00, r_lo};
                w_ma    = ea;
                n_state = ST_DONE;
                if (r_op == OP_LDA_S) begin
                    n_state = ST_MEMRD;
                end else begin
                    w_we = 1'b1;
                    w_wd = r_a;
                end
            end
            ST_PL0: begin
                w_ma    = SP_CELL;
                n_state = ST_PL1;
            end
            ST_PL1: begin
                n_sp    = r_rdata + 8'd1;
                w_ma    = SP_CELL;
                w_we    = 1'b1;
                w_wd    = r_rdata + 8'd1;
                n_state = ST_PL2;
            end
            ST_PL2: begin
                w_ma    = STACK_BASE | {8'h00, r_sp};
                n_state = ST_PL3;
            end
            ST_PL3: begin
                n_state = ST_DONE;
                unique case (r_op) inside
                    OP_PLA: begin alu = f_load(r_rdata); do_seta = 1'b1; end
                    OP_PLX: begin alu = f_load(r_rdata); do_alu = 1'b1; n_x = r_rdata; end
                    OP_PLY: begin alu = f_load(r_rdata); do_alu = 1'b1; n_y = r_rdata; end
                    default: begin
                        // Return pulls the high byte first, then the low byte.
                        if (!r_second) begin
                            n_hi     = r_rdata;
                            n_second = 1'b1;
                            n_state  = ST_PL0;
                        end else begin
                            n_pc = {r_hi, r_rdata} + 16'd2;
                        end
                    end
                endcase
            end
            ST_PU0: begin
                w_ma    = SP_CELL;
                n_state = ST_PU1;
            end
            ST_PU1: begin
                w_ma    = STACK_BASE | {8'h00, r_rdata};
                w_we    = 1'b1;
                w_wd    = r_pv;
                n_state = ST_PU2;
            end
            ST_PU2: begin
                // The pointer is read again: the stack write may have hit it.
                w_ma    = SP_CELL;
                n_state = ST_PU3;
            end
            ST_PU3: begin
                w_ma    = SP_CELL;
                w_we    = 1'b1;
                w_wd    = r_rdata - 8'd1;
                n_state = ST_DONE;
                if (r_op == OP_JSR) begin
                    if (!r_second) begin
                        n_pv     = r_ret[15:8];
                        n_second = 1'b1;
                        n_state  = ST_PU0;
                    end else begin
                        n_pc = r_t16;
                    end
                end
            end
            ST_DONE: begin
                n_ovalid           = 1'b1;
                n_out.read_data    = (r_cmd == CMD_READ) ? r_rdata : 8'h00;
                n_out.prog_counter = r_pc;
                n_out.accum        = r_acc;
                n_out.reg_a_val    = r_a;
                n_out.reg_x_val    = r_x;
                n_out.reg_y_val    = r_y;
                n_out.zero_bit     = r_zf;
                n_out.carry_bit    = r_cf;
                n_out.out_valid    = r_ov;
                n_out.out_char     = r_oc;
                n_out.status       = r_halt;
                n_state            = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        if (do_alu || do_seta) begin
            n_acc = alu.acc;
            n_cf  = alu.cf;
            n_zf  = alu.zf;
        end
        if (do_seta) begin
            n_a = alu.acc;
        end
    end

endmodule
`default_nettype wire

/* tb/sv/accumulator_cpu_instruction_step_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module accumulator_cpu_instruction_step_checker import acis_pkg::*; #(
    parameter logic [15:0] STACK_BASE = 16'hFF00,
    parameter logic [15:0] SP_CELL    = 16'hFFFF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    acis_in_if    i_in,
    acis_out_if   i_out,
    output int    o_fail_cnt
);

    logic [7:0]  ram [0:MEM_DEPTH-1];
    logic [15:0] pc;
    logic [7:0]  acc;
    logic [7:0]  ra, rx, ry;
    logic        cf, zf;
    logic [1:0]  halt;
    t_out_item   pending_words [$];
    int          fail_cnt;

    assign o_fail_cnt = fail_cnt;

    function automatic logic [7:0] fetch8();
        logic [7:0] v;
        v  = ram[pc];
        pc = pc + 16'd1;
        return v;
    endfunction

    function automatic logic [15:0] fetch16();
        logic [7:0] lo;
        logic [7:0] hi;
        lo = fetch8();
        hi = fetch8();
        return {hi, lo};
    endfunction

    function automatic logic [15:0] fetch_ptr();
        logic [15:0] p;
        p = fetch16();
        return {ram[p + 16'd1], ram[p]};
    endfunction

    function automatic void load(input logic [7:0] v);
        acc = v;
        cf  = 1'b0;
        zf  = (v == 8'h00);
    endfunction

    function automatic void alu_add(input logic [7:0] v, input logic cin);
        logic [8:0] s;
        s   = {1'b0, acc} + {1'b0, v} + {8'h00, cin};
        acc = s[7:0];
        cf  = s[8];
        zf  = (s[7:0] == 8'h00);
    endfunction

    function automatic void set_a(input logic [7:0] v);
        load(v);
        ra = v;
    endfunction

    function automatic void add_to_a(input logic [7:0] v);
        acc = 8'h00;
        zf  = 1'b1;
        alu_add(ra, cf);
        alu_add(v, cf);
        ra = acc;
    endfunction

    function automatic void sub_from_a(input logic [7:0] v);
        logic c;
        c = cf;
        load(ra);
        alu_add(~v, c);
        ra = acc;
    endfunction

    function automatic void compare(input logic [7:0] r, input logic [7:0] v);
        load(r);
        alu_add(~v, 1'b1);
    endfunction

    function automatic logic [7:0] step_reg(input logic [7:0] r, input logic up);
        load(r);
        if (up) alu_add(8'h00, 1'b1);
        else    alu_add(8'hFF, 1'b0);
        return acc;
    endfunction

    function automatic logic [15:0] stack_addr();
        return STACK_BASE | {8'h00, ram[SP_CELL]};
    endfunction

    function automatic void push(input logic [7:0] v);
        ram[stack_addr()] = v;
        ram[SP_CELL]      = ram[SP_CELL] - 8'd1;
    endfunction

    function automatic logic [7:0] pull();
        ram[SP_CELL] = ram[SP_CELL] + 8'd1;
        return ram[stack_addr()];
    endfunction

    function automatic logic [7:0] rotl(input logic [7:0] v);
        return {v[6:0], v[7]};
    endfunction

    function automatic void run_instruction(input logic [7:0] ch, ref t_out_item w);
        logic [7:0]  op;
        logic [15:0] a;
        logic [15:0] ret;
        logic [7:0]  v;
        logic [7:0]  hi;
        op = fetch8();
        case (op)
            OP_NOP:     halt = HALT_NOP;
            OP_OUT: begin
                a = fetch16();
                load(ra);
                if (a == 16'd1) begin
                    w.out_valid = 1'b1;
                    w.out_char  = ra;
                end
            end
            OP_IN: begin
                a = fetch16();
                if (a == 16'd2) set_a(ch);
            end
            OP_LDA_I:   set_a(fetch8());
            OP_LDX_I:   begin v = fetch8(); load(v); rx = v; end
            OP_LDY_I:   begin v = fetch8(); load(v); ry = v; end
            OP_LDA_M:   set_a(ram[fetch16()]);
            OP_LDA_MX:  set_a(ram[fetch16() + {8'h00, rx}]);
            OP_LDA_MY:  set_a(ram[fetch16() + {8'h00, ry}]);
            OP_LDA_IND: set_a(ram[fetch_ptr()]);
            OP_STA_M:   ram[fetch16()] = ra;
            OP_STX_M:   ram[fetch16()] = rx;
            OP_STY_M:   ram[fetch16()] = ry;
            OP_STA_MX:  ram[fetch16() + {8'h00, rx}] = ra;
            OP_STA_MY:  ram[fetch16() + {8'h00, ry}] = ra;
            OP_STA_IND: ram[fetch_ptr()] = ra;
            OP_INA:     ra = step_reg(ra, 1'b1);
            OP_INX:     rx = step_reg(rx, 1'b1);
            OP_INY:     ry = step_reg(ry, 1'b1);
            OP_DEA:     ra = step_reg(ra, 1'b0);
            OP_DEX:     rx = step_reg(rx, 1'b0);
            OP_DEY:     ry = step_reg(ry, 1'b0);
            OP_TAX:     rx = ra;
            OP_TXA:     set_a(rx);
            OP_TYA:     set_a(ry);
            OP_TAY:     ry = ra;
            OP_TXY:     ry = rx;
            OP_TYX:     rx = ry;
            OP_LDA_SP:  set_a(ram[SP_CELL]);
            OP_STA_SP:  begin load(ra); ram[SP_CELL] = ra; end
            OP_SEC:     cf = 1'b1;
            OP_CLC:     cf = 1'b0;
            OP_ADD_I:   add_to_a(fetch8());
            OP_ADD_M:   add_to_a(ram[fetch16()]);
            OP_ADD_X:   add_to_a(rx);
            OP_ADD_Y:   add_to_a(ry);
            OP_SUB_I:   sub_from_a(fetch8());
            OP_SUB_M:   sub_from_a(ram[fetch16()]);
            OP_SUB_X:   sub_from_a(rx);
            OP_SUB_Y:   sub_from_a(ry);
            OP_NAND_I:  set_a(~(ra & fetch8()));
            OP_NAND_M:  set_a(~(ra & ram[fetch16()]));
            OP_NAND_X:  set_a(~(ra & rx));
            OP_NAND_Y:  set_a(~(ra & ry));
            OP_ROL1:    set_a(rotl(ra));
            OP_ROL2:    set_a({ra[5:0], ra[7:6]});
            OP_ROL4:    set_a({ra[3:0], ra[7:4]});
            OP_AND_I, OP_AND_I2: set_a(ra & fetch8());
            OP_OR_I:    set_a(ra | fetch8());
            OP_NOT:     set_a(~ra);
            OP_XOR_I:   set_a(ra ^ fetch8());
            OP_JMP:     pc = fetch16();
            OP_JZ:      begin a = fetch16(); if (zf) pc = a; end
            OP_JC:      begin a = fetch16(); if (cf) pc = a; end
            OP_JMP_IND: pc = fetch_ptr();
            OP_SP_INIT: ram[SP_CELL] = SP_INIT_VAL;
            OP_PHA:     push(ra);
            OP_PHX:     push(rx);
            OP_PHY:     push(ry);
            OP_PLA:     set_a(pull());
            OP_PLX:     begin v = pull(); load(v); rx = v; end
            OP_PLY:     begin v = pull(); load(v); ry = v; end
            OP_JSR: begin
                ret = pc;
                a   = fetch16();
                push(ret[7:0]);
                push(ret[15:8]);
                pc = a;
            end
            OP_RTS: begin
                hi = pull();
                v  = pull();
                pc = {hi, v} + 16'd2;
            end
            OP_LDA_S:   begin a = stack_addr(); set_a(ram[a + {8'h00, fetch8()}]); end
            OP_STA_S:   begin a = stack_addr(); ram[a + {8'h00, fetch8()}] = ra; end
            OP_CMP_I:   compare(ra, fetch8());
            OP_CMP_M:   compare(ra, ram[fetch16()]);
            OP_CPX_I:   compare(rx, fetch8());
            OP_CPY_I:   compare(ry, fetch8());
            OP_CLR_M:   ram[fetch16()] = 8'h00;
            OP_INC_M, OP_DEC_M: begin
                a      = fetch16();
                ram[a] = step_reg(ram[a], op == OP_INC_M);
            end
            OP_PH_I:    push(fetch8());
            OP_ROLA:    begin acc = 8'h00; zf = 1'b1; ra = rotl(ra); end
            OP_ROL_M: begin
                acc    = 8'h00;
                zf     = 1'b1;
                a      = fetch16();
                ram[a] = rotl(ram[a]);
            end
            OP_OR_M:    set_a(ram[fetch16()] | ra);
            default:    halt = HALT_BAD;
        endcase
    endfunction

    function automatic t_out_item predict_word(input t_in_item it);
        t_out_item w;
        w = '0;
        if (it.opcode == ITEM_WR)
            ram[it.mem_addr] = it.mem_data;
        else if (it.opcode == ITEM_RD)
            w.read_data = ram[it.mem_addr];
        else if (it.opcode == ITEM_EXEC && halt == HALT_RUN)
            run_instruction(it.in_char, w);
        w.prog_counter = pc;
        w.accum        = acc;
        w.reg_a_val    = ra;
        w.reg_x_val    = rx;
        w.reg_y_val    = ry;
        w.zero_bit     = zf;
        w.carry_bit    = cf;
        w.status       = halt;
        return w;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        t_out_item g;
        if (!i_rst_n) begin
            for (int k = 0; k < MEM_DEPTH; k++) ram[k] = 8'h00;
            pc   = 16'h0000;
            acc  = 8'h00;
            ra   = 8'h00;
            rx   = 8'h00;
            ry   = 8'h00;
            cf   = 1'b0;
            zf   = 1'b0;
            halt = HALT_RUN;
            pending_words.delete();
        end else begin
            if (i_in.valid && i_in.ready)
                pending_words.push_back(predict_word(i_in.data));
            if (i_out.valid && i_out.ready) begin
                g = i_out.data;
                if (pending_words.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result word 0x%0h", $time, g);
                end else begin
                    e = pending_words.pop_front();
                    check_field("read_data", e.read_data, g.read_data);
                    check_field("prog_counter", e.prog_counter, g.prog_counter);
                    check_field("accum", e.accum, g.accum);
                    check_field("reg_a", e.reg_a_val, g.reg_a_val);
                    check_field("reg_x", e.reg_x_val, g.reg_x_val);
                    check_field("reg_y", e.reg_y_val, g.reg_y_val);
                    check_field("zero_bit", e.zero_bit, g.zero_bit);
                    check_field("carry_bit", e.carry_bit, g.carry_bit);
                    check_field("out_valid", e.out_valid, g.out_valid);
                    check_field("out_char", e.out_char, g.out_char);
                    check_field("status", e.status, g.status);
                end
            end
        end
    end

    initial fail_cnt = 0;

    final begin
    end

endmodule
`default_nettype wire

/* tb/sv/accumulator_cpu_instruction_step_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module accumulator_cpu_instruction_step_tb;
    import acis_pkg::*;

    localparam int IDLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_cnt;
    int          n_sent;
    int          n_done;
    int          n_exec;
    int          gap_pct;
    int          stall_pct;
    int          idle_cycles;
    logic [15:0] last_pc;

    acis_in_if  in_ch ();
    acis_out_if out_ch ();

    accumulator_cpu_instruction_step i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    accumulator_cpu_instruction_step_checker i_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_fail_cnt (fail_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_done  <= n_done + 1;
            last_pc <= out_ch.data.prog_counter;
        end
    end

    // Reset clearing of the RAM counts as idle time too, hence the wide limit.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [15:0] addr,
                             input logic [7:0] dat, input logic [7:0] ch);
        t_in_item w;
        while ($urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        w.opcode   = cmd;
        w.mem_addr = addr;
        w.mem_data = dat;
        w.in_char  = ch;
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        n_sent++;
        if (cmd == ITEM_EXEC) n_exec++;
    endtask

    task automatic drain();
        if (n_sent != n_done) begin
            in_ch.valid <= 1'b0;
            while (n_sent != n_done) @(posedge i_clk);
        end
    endtask

    // Places one instruction at the current program counter and executes it.
    task automatic run_op(input logic [7:0] op, input logic [7:0] b1,
                          input logic [7:0] b2, input logic [7:0] ch);
        logic [15:0] p;
        drain();
        p = last_pc;
        send_word(ITEM_WR, p, op, 8'($urandom));
        send_word(ITEM_WR, p + 16'd1, b1, 8'($urandom));
        send_word(ITEM_WR, p + 16'd2, b2, 8'($urandom));
        send_word(ITEM_EXEC, 16'($urandom), 8'($urandom), ch);
    endtask

    task automatic set_phase();
        if (n_sent < 120)      begin gap_pct = 0;  stall_pct = 0;  end
        else if (n_sent < 240) begin gap_pct = 78; stall_pct = 0;  end
        else if (n_sent < 360) begin gap_pct = 0;  stall_pct = 78; end
        else                   begin gap_pct = 10; stall_pct = 10; end
    endtask

    initial begin
        logic [7:0]  op;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [15:0] a;
        int          pick;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        n_sent       = 0;
        n_done       = 0;
        n_exec       = 0;
        idle_cycles  = 0;
        last_pc      = 16'h0000;
        gap_pct      = 0;
        stall_pct    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, the unused item code, and special cases.
        send_word(ITEM_WR, 16'hFFFF, 8'hFF, 8'h00);
        send_word(ITEM_RD, 16'hFFFF, 8'h00, 8'hFF);
        send_word(ITEM_RD, 16'h0000, 8'hFF, 8'h00);
        send_word(2'(CMD_NONE), 16'hA5A5, 8'h5A, 8'hC3);
        run_op(OP_LDA_I, 8'hFF, 8'h00, 8'h00);
        run_op(OP_SEC, 8'h00, 8'h00, 8'h00);
        run_op(OP_ADD_I, 8'hFF, 8'h00, 8'h00);
        run_op(OP_SUB_I, 8'h01, 8'h00, 8'h00);
        run_op(OP_LDA_I, 8'h81, 8'h00, 8'h00);
        run_op(OP_ROL1, 8'h00, 8'h00, 8'h00);
        run_op(OP_ROLA, 8'h00, 8'h00, 8'h00);
        run_op(OP_ROL_M, 8'h00, 8'h30, 8'h00);
        run_op(OP_OUT, 8'h01, 8'h00, 8'h00);
        run_op(OP_IN, 8'h02, 8'h00, 8'hE7);
        run_op(OP_IN, 8'h03, 8'h00, 8'h18);
        run_op(OP_SP_INIT, 8'h00, 8'h00, 8'h00);
        run_op(OP_PH_I, 8'h42, 8'h00, 8'h00);
        run_op(OP_LDA_S, 8'h01, 8'h00, 8'h00);
        run_op(OP_STA_S, 8'h02, 8'h00, 8'h00);
        run_op(OP_JSR, 8'h00, 8'h40, 8'h00);
        run_op(OP_RTS, 8'h00, 8'h00, 8'h00);
        run_op(OP_LDX_I, 8'hFF, 8'h00, 8'h00);
        run_op(OP_LDA_MX, 8'h10, 8'hFF, 8'h00);
        run_op(OP_JMP, 8'hFE, 8'hFF, 8'h00);
        run_op(OP_LDA_IND, 8'hFF, 8'hFF, 8'h00);

        while (n_sent < 490) begin
            set_phase();
            pick = $urandom_range(99);
            if (pick < 70) begin
                op = 8'($urandom_range(OP_OUT, OP_OR_M));
                b1 = 8'($urandom);
                // Half the operand addresses fall in a small window for reuse.
                b2 = ($urandom_range(1)) ? 8'h20 : 8'($urandom);
                if ((op == OP_OUT || op == OP_IN) && $urandom_range(1))
                    b2 = 8'h00;
                if (op == OP_OUT && $urandom_range(1)) b1 = 8'h01;
                if (op == OP_IN && $urandom_range(1))  b1 = 8'h02;
                run_op(op, b1, b2, 8'($urandom));
            end else if (pick < 82) begin
                a = ($urandom_range(1)) ? {8'h20, 8'($urandom)} : 16'($urandom);
                send_word(ITEM_WR, a, 8'($urandom), 8'($urandom));
            end else if (pick < 94) begin
                a = ($urandom_range(1)) ? {8'h20, 8'($urandom)} : 16'($urandom);
                send_word(ITEM_RD, a, 8'($urandom), 8'($urandom));
            end else if (pick < 97) begin
                send_word(2'(CMD_NONE), 16'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                // Executes at the PC, usually a random opcode just written.
                drain();
                if (last_pc != 16'h0000 || $urandom_range(1))
                    send_word(ITEM_WR, last_pc, 8'($urandom_range(OP_OUT, OP_OR_M)),
                              8'($urandom));
                send_word(ITEM_EXEC, 16'($urandom), 8'($urandom), 8'($urandom));
            end
        end

        // A halt is final until reset, so it closes the run.
        gap_pct   = 0;
        stall_pct = 0;
        if ($urandom_range(1))
            run_op(OP_NOP, 8'h00, 8'h00, 8'h00);
        else
            run_op(8'($urandom_range(OP_OR_M + 1, 8'hFF)), 8'h00, 8'h00, 8'h00);
        send_word(ITEM_EXEC, 16'h0000, 8'h00, 8'h00);
        send_word(ITEM_WR, 16'h1234, 8'hAB, 8'h00);
        send_word(ITEM_RD, 16'h1234, 8'h00, 8'h00);
        send_word(ITEM_EXEC, 16'hFFFF, 8'hFF, 8'hFF);
        drain();
        repeat (40) @(posedge i_clk);

        $display("Moved %0d words through the block, %0d of them executed instructions,",
                 n_sent, n_exec);
        $display("under free-running, sender-idle, receiver-stall and mixed phases.");
        if (fail_cnt == 0 && n_sent == n_done)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
